@@ rtl/bce_pkg.sv @@
`default_nettype none

package bce_pkg;

    // Default sizes of the cascade.
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int MAX_STAGES_DEF   = 3;
    localparam int SAMPLE_W_DEF     = 24;

    // Fixed-point formats.
    localparam int COEF_W     = 21;
    localparam int COEF_FRAC  = 18;
    localparam int DELAY_W    = 40;
    localparam int DELAY_FRAC = 12;
    localparam int X_SHIFT    = COEF_FRAC - DELAY_FRAC;

    // Configuration port.
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int FF_W      = 3 * COEF_W;
    localparam int FB_W      = 2 * COEF_W;
    localparam logic [FF_W-1:0] FF_RESET = FF_W'(262144);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STAGE_COUNT = 3'd0,
        REG_CHAN_COUNT  = 3'd1,
        REG_STAGE0_FF   = 3'd2,
        REG_STAGE0_FB   = 3'd3,
        REG_STAGE1_FF   = 3'd4,
        REG_STAGE1_FB   = 3'd5,
        REG_STAGE2_FF   = 3'd6,
        REG_STAGE2_FB   = 3'd7
    } t_reg_idx;

    // Coefficient set of one section, Q3.18 each.
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coef;

endpackage

`default_nettype wire

@@ rtl/bce_cell.sv @@
`default_nettype none

// One biquad section. Holds z1 and z2 for every channel and runs the
// transposed direct form II update in three steps; an inactive section
// forwards the sample in the next cycle without touching its delays.
module bce_cell #(
    parameter int SAMPLE_W     = bce_pkg::SAMPLE_W_DEF,
    parameter int MAX_CHANNELS = bce_pkg::MAX_CHANNELS_DEF,
    parameter int CH_W         = 3
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  wire                        i_active,
    input  wire [CH_W-1:0]             i_ch,
    input  wire signed [SAMPLE_W-1:0]  i_x,
    input  wire bce_pkg::t_coef        i_coef,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_x
);
    import bce_pkg::*;

    localparam int PW  = COEF_W + SAMPLE_W;
    localparam int PSW = PW - X_SHIFT;
    localparam int SW  = ((PSW > DELAY_W) ? PSW : DELAY_W) + 1;
    localparam int MW  = COEF_W + DELAY_W;
    localparam int MSW = MW - COEF_FRAC;
    localparam int TW  = ((SW > MSW) ? SW : MSW) + 1;
    localparam int RNW = DELAY_W + 1;
    localparam int RSW = RNW - DELAY_FRAC;
    localparam int XW  = ((RSW > SAMPLE_W) ? RSW : SAMPLE_W) + 1;
    localparam logic signed [RNW-1:0] HALF = RNW'(1) << (DELAY_FRAC - 1);

    function automatic logic signed [DELAY_W-1:0] sat_d(input logic signed [TW-1:0] v);
        logic [TW-DELAY_W:0] hi;
        hi = v[TW-1:DELAY_W-1];
        if (&hi || ~|hi) begin
            return v[DELAY_W-1:0];
        end
        return {v[TW-1], {(DELAY_W-1){~v[TW-1]}}};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_x(input logic signed [XW-1:0] v);
        logic [XW-SAMPLE_W:0] hi;
        hi = v[XW-1:SAMPLE_W-1];
        if (&hi || ~|hi) begin
            return v[SAMPLE_W-1:0];
        end
        return {v[XW-1], {(SAMPLE_W-1){~v[XW-1]}}};
    endfunction

    logic signed [DELAY_W-1:0]  r_z1 [MAX_CHANNELS];
    logic signed [DELAY_W-1:0]  r_z2 [MAX_CHANNELS];
    logic                       r_ph1, r_ph2, r_ph3;
    logic                       r_act;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [PW-1:0]       r_p0, r_p1, r_p2;
    logic signed [DELAY_W-1:0]  r_zr1, r_zr2;
    logic signed [DELAY_W-1:0]  r_y;
    logic signed [SW-1:0]       r_q1, r_q2;
    logic signed [MW-1:0]       r_m1, r_m2;
    logic signed [SAMPLE_W-1:0] r_xo;

    logic signed [PSW-1:0]      w_p0s, w_p1s, w_p2s;
    logic signed [SW-1:0]       w_s0;
    logic signed [MSW-1:0]      w_m1s, w_m2s;
    logic signed [RNW-1:0]      w_rnd;
    logic signed [RSW-1:0]      w_rsh;

    always_comb begin
        w_p0s = $signed(r_p0[PW-1:X_SHIFT]);
        w_p1s = $signed(r_p1[PW-1:X_SHIFT]);
        w_p2s = $signed(r_p2[PW-1:X_SHIFT]);
        w_s0  = SW'(w_p0s) + SW'(r_zr1);
        w_m1s = $signed(r_m1[MW-1:COEF_FRAC]);
        w_m2s = $signed(r_m2[MW-1:COEF_FRAC]);
        w_rnd = RNW'(r_y) + HALF;
        w_rsh = $signed(w_rnd[RNW-1:DELAY_FRAC]);
    end

    // Step control and per-channel delays.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1 <= 1'b0;
            r_ph2 <= 1'b0;
            r_ph3 <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_z1[c] <= '0;
                r_z2[c] <= '0;
            end
        end else begin
            r_ph1 <= i_valid;
            r_ph2 <= r_ph1 & r_act;
            r_ph3 <= r_ph2;
            if (r_ph3) begin
                r_z1[i_ch] <= sat_d(TW'(r_q1) - TW'(w_m1s));
                r_z2[i_ch] <= sat_d(TW'(r_q2) - TW'(w_m2s));
            end
        end
    end

    // Datapath: feedforward products, section output, feedback products.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_act <= i_active;
            r_x   <= i_x;
            r_p0  <= PW'(i_coef.b0) * PW'(i_x);
            r_p1  <= PW'(i_coef.b1) * PW'(i_x);
            r_p2  <= PW'(i_coef.b2) * PW'(i_x);
            r_zr1 <= r_z1[i_ch];
            r_zr2 <= r_z2[i_ch];
        end
        if (r_ph1) begin
            r_y  <= sat_d(TW'(w_s0));
            r_q1 <= SW'(w_p1s) + SW'(r_zr2);
            r_q2 <= SW'(w_p2s);
        end
        if (r_ph2) begin
            r_m1 <= MW'(i_coef.a1) * MW'(r_y);
            r_m2 <= MW'(i_coef.a2) * MW'(r_y);
            r_xo <= sat_x(XW'(w_rsh));
        end
    end

    assign o_valid = (r_ph1 & ~r_act) | r_ph3;
    assign o_x     = r_act ? r_xo : r_x;

endmodule

`default_nettype wire

@@ rtl/biquad_cascade_equalizer_top.sv @@
// A request is registered at accept, runs through the chain of section cells, waits
// in the pending register and then moves into the output register that drives o_valid.
// Only then is the next request taken; each active cell of the chain takes three steps.
// Reset (i_rst_n low at a clock edge) clears all delays, the channel position
// and the control state, and restores every configuration register.
`default_nettype none

module biquad_cascade_equalizer_top #(
    parameter int MAX_CHANNELS = bce_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_STAGES   = bce_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_WIDTH = bce_pkg::SAMPLE_W_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Input request channel.
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire signed [SAMPLE_WIDTH-1:0]   i_sample_in,
    input  wire                             i_block_end,
    // Result request channel.
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  o_sample_out,
    output logic [2:0]                      o_channel_out,
    output logic                            o_block_end_out,
    // Configuration write port.
    input  wire                             i_cfg_wr_en,
    input  wire [bce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [bce_pkg::CFG_W-1:0]        i_cfg_data
);
    import bce_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int EW    = (CNT_W > 4) ? CNT_W : 4;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are to arrive only while the block is idle;
    // the block itself does not enforce this. The cells read the coefficients directly.
    // ------------------------------------------------------------------
    logic [1:0]       r_stage_count;
    logic [3:0]       r_chan_count;
    logic [FF_W-1:0]  r_ff [MAX_STAGES];
    logic [FB_W-1:0]  r_fb [MAX_STAGES];

    logic             w_ff_we, w_fb_we;
    logic [1:0]       w_cfg_stage;

    // Stage registers come in pairs from index 2 upward.
    assign w_cfg_stage = 2'((i_cfg_index - CFG_IDX_W'(REG_STAGE0_FF)) >> 1);

    always_comb begin
        w_ff_we = 1'b0;
        w_fb_we = 1'b0;
        case (t_reg_idx'(i_cfg_index))
            REG_STAGE0_FF, REG_STAGE1_FF, REG_STAGE2_FF: w_ff_we = i_cfg_wr_en;
            REG_STAGE0_FB, REG_STAGE1_FB, REG_STAGE2_FB: w_fb_we = i_cfg_wr_en;
            default: begin
                w_ff_we = 1'b0;
                w_fb_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_count <= 2'd1;
            r_chan_count  <= 4'd1;
            for (int k = 0; k < MAX_STAGES; k++) begin
                r_ff[k] <= FF_RESET;
                r_fb[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en && t_reg_idx'(i_cfg_index) == REG_STAGE_COUNT) begin
                r_stage_count <= i_cfg_data[1:0];
            end
            if (i_cfg_wr_en && t_reg_idx'(i_cfg_index) == REG_CHAN_COUNT) begin
                r_chan_count <= i_cfg_data[3:0];
            end
            // A stage beyond the built cascade ignores its writes.
            for (int k = 0; k < MAX_STAGES; k++) begin
                if (w_ff_we && w_cfg_stage == 2'(k)) begin
                    r_ff[k] <= i_cfg_data[FF_W-1:0];
                end
                if (w_fb_we && w_cfg_stage == 2'(k)) begin
                    r_fb[k] <= i_cfg_data[FB_W-1:0];
                end
            end
        end
    end

    // Out-of-range counts are clamped: zero acts as one, and anything above
    // the built size acts as the built size.
    logic [1:0]    w_eff_stages;
    logic [EW-1:0] w_eff_chans;

    always_comb begin
        if (r_stage_count == 2'd0) begin
            w_eff_stages = 2'd1;
        end else if (r_stage_count > 2'(MAX_STAGES)) begin
            w_eff_stages = 2'(MAX_STAGES);
        end else begin
            w_eff_stages = r_stage_count;
        end
        if (r_chan_count == 4'd0) begin
            w_eff_chans = EW'(1);
        end else if (EW'(r_chan_count) > EW'(MAX_CHANNELS)) begin
            w_eff_chans = EW'(MAX_CHANNELS);
        end else begin
            w_eff_chans = EW'(r_chan_count);
        end
    end

    // ------------------------------------------------------------------
    // Channel tracking. A stale position at or beyond the channel count
    // (left over from a register change) is taken as channel 0.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] r_pos;
    logic [CH_W-1:0] w_ch, w_next_pos;

    always_comb begin
        if (EW'(r_pos) >= w_eff_chans) begin
            w_ch = '0;
        end else begin
            w_ch = r_pos;
        end
        if (EW'(w_ch) + EW'(1) >= w_eff_chans) begin
            w_next_pos = '0;
        end else begin
            w_next_pos = w_ch + CH_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Request intake. One request is in the cell chain at a time; the block
    // stalls from accept until its result has moved into the output register,
    // so a finished result may wait there while the next request is taken.
    // ------------------------------------------------------------------
    logic                           r_busy;
    logic                           r_start;
    logic signed [SAMPLE_WIDTH-1:0] r_x_in;
    logic [CH_W-1:0]                r_ch;
    logic                           r_be;
    logic                           r_pend_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_pend_x;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_x;
    logic [2:0]                     r_out_ch;
    logic                           r_out_be;

    logic                           w_accept;
    logic                           w_move;
    logic                           w_done;

    assign w_accept = i_valid & ~r_busy;
    assign w_move   = r_pend_valid & (~r_out_valid | ~i_stall);

    // ------------------------------------------------------------------
    // Chain of section cells. Each cell hands its output sample to the next
    // one; cells at or beyond the active stage count pass the sample along.
    // ------------------------------------------------------------------
    logic [MAX_STAGES:0]            w_vld;
    logic signed [SAMPLE_WIDTH-1:0] w_x [MAX_STAGES+1];
    t_coef                          w_coef [MAX_STAGES];

    assign w_vld[0] = r_start;
    assign w_x[0]   = r_x_in;
    assign w_done   = w_vld[MAX_STAGES];

    for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
        assign w_coef[k].b0 = r_ff[k][COEF_W-1:0];
        assign w_coef[k].b1 = r_ff[k][2*COEF_W-1:COEF_W];
        assign w_coef[k].b2 = r_ff[k][3*COEF_W-1:2*COEF_W];
        assign w_coef[k].a1 = r_fb[k][COEF_W-1:0];
        assign w_coef[k].a2 = r_fb[k][2*COEF_W-1:COEF_W];

        bce_cell #(
            .SAMPLE_W     (SAMPLE_WIDTH),
            .MAX_CHANNELS (MAX_CHANNELS),
            .CH_W         (CH_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_vld[k]),
            .i_active (2'(k) < w_eff_stages),
            .i_ch     (r_ch),
            .i_x      (w_x[k]),
            .i_coef   (w_coef[k]),
            .o_valid  (w_vld[k+1]),
            .o_x      (w_x[k+1])
        );
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_start      <= 1'b0;
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_start <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
                r_pos  <= w_next_pos;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_pend_valid <= 1'b1;
            end else if (w_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload. Channel and block end stay put while the request is in flight.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x_in <= i_sample_in;
            r_ch   <= w_ch;
            r_be   <= i_block_end;
        end
        if (w_done) begin
            r_pend_x <= w_x[MAX_STAGES];
        end
        if (w_move) begin
            r_out_x  <= r_pend_x;
            r_out_ch <= 3'(r_ch);
            r_out_be <= r_be;
        end
    end

    assign o_stall         = r_busy;
    assign o_valid         = r_out_valid;
    assign o_sample_out    = r_out_x;
    assign o_channel_out   = r_out_ch;
    assign o_block_end_out = r_out_be;

`ifndef SYNTHESIS
    // Only one request travels through the cell chain at a time.
    a_one_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one cell handoff in flight");

    // A result leaves the chain only for a request still held as busy,
    // and never while an earlier result still waits to move out.
    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_busy && !r_pend_valid))
        else $error("chain result without an open request");

    // Right after an accept the block stalls and takes no other request.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_stall && !w_accept))
        else $error("request taken while another is in flight");

    // A waiting result always belongs to an open request.
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_busy)
        else $error("pending result without an open request");
`endif

endmodule

`default_nettype wire

@@ tb/tb_biquad_cascade_equalizer_top.sv @@
`default_nettype none

module tb_biquad_cascade_equalizer_top;

    import bce_pkg::*;

    localparam int N_STAGES    = MAX_STAGES_DEF;
    localparam int N_CHANNELS  = MAX_CHANNELS_DEF;
    localparam int SAMPLE_BITS = SAMPLE_W_DEF;

    // Coefficient rails and unity gain in Q3.18.
    localparam int COEF_HI = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_LO = -(1 << (COEF_W - 1));
    localparam int UNITY   = 1 << COEF_FRAC;

    // Length of the deliberate output hold-off, in clock cycles.
    localparam int LONG_HOLD = 400;
    // Only the first few mismatches are printed; the rest are just counted.
    localparam int MAX_PRINTED = 40;

    // Scoreboard: keeps its own copy of the registers, the per-channel delay
    // lines and the channel counter, filters every accepted request and
    // queues the result that the block owes for it.
    class eq_scoreboard;
        typedef struct {
            logic signed [SAMPLE_BITS-1:0] sample;
            logic [2:0]                    channel;
            logic                          block_end;
        } t_result;

        logic [1:0]      stage_count;
        logic [3:0]      channel_count;
        logic [FF_W-1:0] stage_ff [N_STAGES];
        logic [FB_W-1:0] stage_fb [N_STAGES];
        longint          z1 [N_STAGES][N_CHANNELS];
        longint          z2 [N_STAGES][N_CHANNELS];
        int unsigned     position;
        t_result         expected_out [$];
        int unsigned     n_checked;
        int unsigned     n_clipped;

        function new();
            stage_count   = 2'd1;
            channel_count = 4'd1;
            for (int k = 0; k < N_STAGES; k++) begin
                stage_ff[k] = FF_RESET;
                stage_fb[k] = '0;
                for (int c = 0; c < N_CHANNELS; c++) begin
                    z1[k][c] = 0;
                    z2[k][c] = 0;
                end
            end
            position  = 0;
            n_checked = 0;
            n_clipped = 0;
        endfunction

        function void apply_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_STAGE_COUNT: stage_count = data[1:0];
                REG_CHAN_COUNT:  channel_count = data[3:0];
                REG_STAGE0_FF:   stage_ff[0] = data[FF_W-1:0];
                REG_STAGE0_FB:   stage_fb[0] = data[FB_W-1:0];
                REG_STAGE1_FF:   stage_ff[1] = data[FF_W-1:0];
                REG_STAGE1_FB:   stage_fb[1] = data[FB_W-1:0];
                REG_STAGE2_FF:   stage_ff[2] = data[FF_W-1:0];
                REG_STAGE2_FB:   stage_fb[2] = data[FB_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, int unsigned bits);
            longint hi;
            hi = (longint'(1) << (bits - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function longint coef(logic [CFG_W-1:0] word, int unsigned slot);
            logic signed [COEF_W-1:0] c;
            c = word[slot*COEF_W +: COEF_W];
            return c;
        endfunction

        function int unsigned pending();
            return expected_out.size();
        endfunction

        // Runs one sample through the active sections of its channel.
        function void note_sample(logic signed [SAMPLE_BITS-1:0] sample_in, logic block_end);
            t_result     r;
            int unsigned stages, chans, ch;
            longint      x, y, b0, b1, b2, a1, a2, nz1, nz2;
            stages = (stage_count == 0) ? 1 : stage_count;
            if (stages > N_STAGES) stages = N_STAGES;
            chans = (channel_count == 0) ? 1 : channel_count;
            if (chans > N_CHANNELS) chans = N_CHANNELS;
            ch = (position >= chans) ? 0 : position;
            x = sample_in;
            for (int s = 0; s < stages; s++) begin
                b0 = coef(stage_ff[s], 0);
                b1 = coef(stage_ff[s], 1);
                b2 = coef(stage_ff[s], 2);
                a1 = coef(stage_fb[s], 0);
                a2 = coef(stage_fb[s], 1);
                y   = clamp(((b0 * x) >>> X_SHIFT) + z1[s][ch], DELAY_W);
                nz1 = clamp(((b1 * x) >>> X_SHIFT) - ((a1 * y) >>> COEF_FRAC) + z2[s][ch],
                            DELAY_W);
                nz2 = clamp(((b2 * x) >>> X_SHIFT) - ((a2 * y) >>> COEF_FRAC), DELAY_W);
                z1[s][ch] = nz1;
                z2[s][ch] = nz2;
                x = clamp((y + (longint'(1) << (DELAY_FRAC - 1))) >>> DELAY_FRAC, SAMPLE_BITS);
            end
            if (x == clamp(longint'(1) << 40, SAMPLE_BITS) ||
                x == clamp(-(longint'(1) << 40), SAMPLE_BITS))
                n_clipped++;
            r.sample    = SAMPLE_BITS'(x);
            r.channel   = 3'(ch);
            r.block_end = block_end;
            expected_out.push_back(r);
            position = (ch + 1 >= chans) ? 0 : ch + 1;
        endfunction

        // Returns an empty string when the result matches the oldest one owed.
        function string check_result(logic signed [SAMPLE_BITS-1:0] sample, logic [2:0] channel,
                                     logic block_end);
            t_result e;
            if (expected_out.size() == 0)
                return $sformatf("result with nothing owed: sample %0d channel %0d end %0b",
                                 sample, channel, block_end);
            e = expected_out.pop_front();
            n_checked++;
            if (sample !== e.sample || channel !== e.channel || block_end !== e.block_end)
                return $sformatf("result %0d: got sample %0d ch %0d end %0b, want %0d ch %0d end %0b",
                                 n_checked, sample, channel, block_end,
                                 e.sample, e.channel, e.block_end);
            return "";
        endfunction
    endclass

    // Block inputs start at known values before the first clock edge.
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic                          i_block_end = 1'b0;
    logic                          i_stall     = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_W-1:0]              i_cfg_data  = '0;
    logic                          o_stall;
    logic                          o_valid;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic [2:0]                    o_channel_out;
    logic                          o_block_end_out;

    eq_scoreboard eq_sb = new();

    int n_errors      = 0;
    int n_requests    = 0;
    int n_settings    = 0;
    int hold_requests = 0;
    int holds_done    = 0;

    biquad_cascade_equalizer_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_in     (i_sample_in),
        .i_block_end     (i_block_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sample_out    (o_sample_out),
        .o_channel_out   (o_channel_out),
        .o_block_end_out (o_block_end_out),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Both monitors look at the values that were present just before the
    // rising edge. Every accepted input request is filtered right away, and
    // every accepted result request is checked against the oldest one owed.
    // A result reaches the output only through the registered cell chain, so
    // the two never touch the same entry at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            eq_sb.note_sample(i_sample_in, i_block_end);
            n_requests++;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            msg = eq_sb.check_result(o_sample_out, o_channel_out, o_block_end_out);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    // The result side runs its own stall pattern: stretches without any
    // stall, light and heavy random stalls, and a regular periodic stall.
    // When the stimulus asks for a long hold-off, the stall is held high
    // here for the whole hold-off while the sender keeps offering requests.
    initial begin : result_stall
        int unsigned mode, span, tick, held;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 160);
            for (tick = 0; tick < span; tick++) begin
                @(negedge i_clk);
                if (holds_done != hold_requests) begin
                    holds_done++;
                    i_stall = 1'b1;
                    for (held = 1; held < LONG_HOLD; held++)
                        @(negedge i_clk);
                end else begin
                    case (mode)
                        0:       i_stall = 1'b0;
                        1:       i_stall = ($urandom_range(0, 9) < 3);
                        2:       i_stall = ($urandom_range(0, 9) < 7);
                        default: i_stall = (tick % 4 == 3);
                    endcase
                end
            end
        end
    end

    // Offers one sample and returns once the block has taken it. Valid is
    // left high so that a following request is offered without a gap.
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sample, logic block_end);
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_sample_in = sample;
        i_block_end = block_end;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_cycles(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // Stops sending and waits until the block has delivered every result owed.
    task automatic wait_drained();
        idle_cycles(1);
        while (eq_sb.pending() != 0)
            @(posedge i_clk);
        idle_cycles(2);
    endtask

    // Register writes happen only while the block is drained.
    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        eq_sb.apply_reg(idx, data);
    endtask

    function automatic logic [CFG_W-1:0] pack_ff(int b0, int b1, int b2);
        return {COEF_W'(b2), COEF_W'(b1), COEF_W'(b0)};
    endfunction

    function automatic logic [CFG_W-1:0] pack_fb(int a1, int a2);
        return CFG_W'({COEF_W'(a2), COEF_W'(a1)});
    endfunction

    function automatic int rail_coef();
        case ($urandom_range(0, 2))
            0:       return COEF_HI;
            1:       return COEF_LO;
            default: return 0;
        endcase
    endfunction

    // Full-range noise and quiet signals in equal parts, else the sample rails, minus one or zero.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return SAMPLE_BITS'($urandom);
        if (r < 8)
            return SAMPLE_BITS'(int'($urandom_range(0, 131071)) - 65536);
        case ($urandom_range(0, 3))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2:       return '1;
            default: return '0;
        endcase
    endfunction

    // Picks the coefficients of one section. Most sections are stable
    // filters with random poles and zeros; the rest are raw random words,
    // coefficient rails that drive the delays into saturation, or unity gain.
    // Unused upper bits of the feedback word are filled with noise.
    task automatic pick_section(bit force_stable, output logic [CFG_W-1:0] ff,
                                output logic [CFG_W-1:0] fb);
        int unsigned r;
        int          a1, a2, lim;
        r = force_stable ? 0 : $urandom_range(0, 9);
        if (r < 6) begin
            a2  = int'($urandom_range(0, 2 * 235929)) - 235929;
            lim = (UNITY + a2) * 95 / 100;
            a1  = int'($urandom_range(0, 2 * lim)) - lim;
            ff  = pack_ff(int'($urandom_range(0, 2 * UNITY)) - UNITY,
                          int'($urandom_range(0, 2 * UNITY)) - UNITY,
                          int'($urandom_range(0, 2 * UNITY)) - UNITY);
            fb  = pack_fb(a1, a2);
        end else if (r < 7) begin
            ff = CFG_W'({$urandom, $urandom});
            fb = CFG_W'({$urandom, $urandom});
        end else if (r < 8) begin
            ff = pack_ff(rail_coef(), rail_coef(), rail_coef());
            fb = pack_fb(rail_coef(), rail_coef());
        end else begin
            ff = FF_RESET;
            fb = '0;
        end
        fb[CFG_W-1:FB_W] = (CFG_W - FB_W)'($urandom);
    endtask

    // Writes every register. The first two settings are the extremes of the
    // cascade: all three sections on eight channels, then one section on one
    // channel. Later ones are random, now and then with out-of-range counts.
    task automatic configure_setting(int unsigned idx);
        logic [CFG_W-1:0] d, ff, fb;
        logic [1:0]       sc;
        logic [3:0]       cc;
        case (idx)
            0: begin
                sc = 2'd3;
                cc = 4'd8;
            end
            1: begin
                sc = 2'd1;
                cc = 4'd1;
            end
            default: begin
                sc = 2'($urandom_range(0, 3));
                cc = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 8));
            end
        endcase
        d = CFG_W'({$urandom, $urandom});
        d[1:0] = sc;
        write_reg(REG_STAGE_COUNT, d);
        d = CFG_W'({$urandom, $urandom});
        d[3:0] = cc;
        write_reg(REG_CHAN_COUNT, d);
        for (int k = 0; k < N_STAGES; k++) begin
            pick_section(idx == 0, ff, fb);
            write_reg(t_reg_idx'(int'(REG_STAGE0_FF) + 2 * k), ff);
            write_reg(t_reg_idx'(int'(REG_STAGE0_FB) + 2 * k), fb);
        end
        n_settings++;
    endtask

    // Random traffic in bursts, with gaps of random length between them.
    // About a quarter of the bursts run straight into the next one.
    task automatic run_traffic(int unsigned total);
        int unsigned sent, burst, gap;
        sent = 0;
        while (sent < total) begin
            burst = $urandom_range(1, 24);
            if (burst > total - sent)
                burst = total - sent;
            repeat (burst)
                send_sample(pick_sample(), $urandom_range(0, 7) == 0);
            sent += burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            idle_cycles(gap);
        end
    endtask

    initial begin : stimulus
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // With the reset settings the cascade is a single unity-gain section,
        // so the sample rails, zero and plus or minus one must pass untouched.
        send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}}, 1'b1);
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}}, 1'b0);
        send_sample('0, 1'b1);
        send_sample('1, 1'b0);
        send_sample(SAMPLE_BITS'(1), 1'b1);
        wait_drained();

        // Coefficient rails on two channels: the first section runs its delays
        // into the 40-bit limits and the second, at a gain of minus four,
        // drives the output against both 24-bit rails.
        write_reg(REG_STAGE_COUNT, CFG_W'(3));
        write_reg(REG_CHAN_COUNT, CFG_W'(2));
        write_reg(REG_STAGE0_FF, pack_ff(COEF_HI, COEF_LO, COEF_HI));
        write_reg(REG_STAGE0_FB, pack_fb(COEF_LO, COEF_HI));
        write_reg(REG_STAGE1_FF, pack_ff(COEF_LO, 0, 0));
        write_reg(REG_STAGE1_FB, '0);
        send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}}, 1'b0);
        send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}}, 1'b1);
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}}, 1'b0);
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}}, 1'b1);
        send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}}, 1'b0);
        send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}}, 1'b1);
        wait_drained();

        // A channel count above eight acts as eight. Shrinking the count to
        // three while the counter stands at five restarts it at channel zero.
        // Then a zero stage count and a zero channel count both act as one.
        write_reg(REG_CHAN_COUNT, CFG_W'(15));
        repeat (5) send_sample(pick_sample(), 1'b0);
        wait_drained();
        write_reg(REG_CHAN_COUNT, CFG_W'(3));
        repeat (2) send_sample(pick_sample(), 1'b1);
        wait_drained();
        write_reg(REG_CHAN_COUNT, CFG_W'(0));
        write_reg(REG_STAGE_COUNT, CFG_W'(0));
        repeat (2) send_sample(pick_sample(), 1'b0);
        n_settings += 5;

        // Random part: eight register settings of about 85 requests each.
        // During the third the result side holds off for a long stretch so
        // that the block backs up; in the fourth the sender stops halfway
        // until every owed result has come back.
        for (int s = 0; s < 8; s++) begin
            wait_drained();
            configure_setting(s);
            if (s == 2)
                hold_requests++;
            if (s == 3) begin
                run_traffic(40);
                wait_drained();
                run_traffic(45);
            end else begin
                run_traffic(85);
            end
        end

        wait_drained();
        repeat (30) @(posedge i_clk);

        $display("Filtered %0d samples over %0d register settings, one to three sections",
                 n_requests, n_settings);
        $display("and one to eight channels; %0d results checked, %0d on the output rails.",
                 eq_sb.n_checked, eq_sb.n_clipped);
        if (n_errors == 0 && eq_sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin : watchdog
        #2000000;
        $display("Run timed out with %0d results still owed.", eq_sb.pending());
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
